FILE: hdl/phpd_pkg.sv
// shared types, constants and codes for the planar hold-and-modify pixel decoder
`default_nettype none
package phpd_pkg;

  // palette store size and address width
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int PAL_W = 24;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  // result queue inside the back part
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW = $clog2(OUT_DEPTH);

  // item kinds
  localparam logic KIND_PIXELS = 1'b0;
  localparam logic KIND_PAL_WR = 1'b1;

  // display modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HAM6 = 2'd1;
  localparam logic [1:0] MODE_HAM8 = 2'd2;

  // per-pixel accumulator operations
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BLUE = 2'd1;
  localparam logic [1:0] OP_RED = 2'd2;
  localparam logic [1:0] OP_GREEN = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_PLANES = 2'd1;
  localparam logic [1:0] REG_HAM = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] WIDTH_RESET = 16'd320;
  localparam logic [3:0] PLANES_RESET = 4'd5;

  typedef struct packed {
    logic        kind;
    logic [63:0] plane_bytes;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        row_end;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] image_width;
    logic [3:0]  plane_count;
    logic        ham_enable;
  } cfg_t;

  // classified item as it waits for the back part
  typedef struct packed {
    logic            kind;
    logic [7:0][7:0] idx;
    logic [3:0]      cnt;
    logic            row_start;
    logic            row_end;
    logic [1:0]      mode;
    logic [7:0]      pal_index;
    logic [23:0]     pal_color;
  } q_entry_t;

endpackage
`default_nettype wire

FILE: hdl/phpd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module phpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/phpd_front.sv
// front part: accepts items, regroups plane bits, tracks the row column, queues work
`default_nettype none
module phpd_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire phpd_pkg::cfg_t      cfg,
  input  wire logic                push,
  output logic                     full,
  input  wire phpd_pkg::in_item_t  in_item,
  output logic                     q_valid,
  output phpd_pkg::q_entry_t       q_head,
  input  wire logic                q_pop
);
  import phpd_pkg::*;

  q_entry_t        q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   q_cnt_r, q_cnt_nxt;
  logic [12:0]     col_r, col_nxt;

  logic            accept;
  logic [15:0]     width;
  logic [3:0]      planes;
  logic [7:0]      mask;
  logic [1:0]      mode;
  logic [13:0]     groups;
  logic [13:0]     col_inc;
  logic [15:0]     base;
  logic [15:0]     rem;
  logic            visible;
  logic [7:0][7:0] idx;
  q_entry_t        entry;

  assign full = (q_cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign accept = push && !full;
  assign q_valid = (q_cnt_r != '0);
  assign q_head = q_mem_r[rd_ptr_r];

  // effective width, plane count and mode
  always_comb begin
    width = (cfg.image_width == '0) ? 16'd1 : cfg.image_width;
    planes = (cfg.plane_count > 4'd8) ? 4'd8 : cfg.plane_count;
    for (int p = 0; p < 8; p++) begin
      mask[p] = (4'(p) < planes);
    end
    mode = MODE_NORMAL;
    if (cfg.ham_enable) begin
      if (planes == 4'd5 || planes == 4'd6) begin
        mode = MODE_HAM6;
      end else if (planes == 4'd7 || planes == 4'd8) begin
        mode = MODE_HAM8;
      end
    end
  end

  // bit regrouping: pixel k takes bit 7-k of each plane byte
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      for (int p = 0; p < 8; p++) begin
        idx[k][p] = in_item.plane_bytes[8*p + 7 - k] & mask[p];
      end
    end
  end

  // visible pixels of this group and column advance
  always_comb begin
    groups = {13'((17'(width) + 17'd15) >> 4), 1'b0};
    base = {col_r, 3'b000};
    visible = (base < width);
    rem = width - base;
    col_inc = {1'b0, col_r} + 14'd1;
    col_nxt = col_r;
    if (accept && in_item.kind == KIND_PIXELS) begin
      col_nxt = (col_inc >= groups) ? 13'd0 : col_inc[12:0];
    end
  end

  // classified entry
  always_comb begin
    entry.kind = in_item.kind;
    entry.idx = idx;
    entry.cnt = !visible ? 4'd0 : ((rem >= 16'd8) ? 4'd8 : rem[3:0]);
    entry.row_start = (col_r == '0);
    entry.row_end = visible && (rem <= 16'd8);
    entry.mode = mode;
    entry.pal_index = in_item.palette_index;
    entry.pal_color = in_item.palette_color;
  end

  // queue pointers
  always_comb begin
    wr_ptr_nxt = accept ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt = q_cnt_r + (Q_AW + 1)'(accept) - (Q_AW + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r <= '0;
      col_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r <= q_cnt_nxt;
      col_r <= col_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  // queue checks
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= (Q_AW + 1)'(Q_DEPTH)) else $error("queue count out of range");
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_PIXELS && col_inc >= groups) |=> col_r == '0)
    else $error("column did not wrap at row end");

endmodule
`default_nettype wire

FILE: hdl/phpd_back.sv
// back part: palette store, per-pixel accumulator update and result queue
`default_nettype none
module phpd_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire phpd_pkg::q_entry_t  q_head,
  output logic                     q_pop,
  output logic                     empty,
  input  wire logic                pop,
  output phpd_pkg::out_item_t      out_item
);
  import phpd_pkg::*;

  // issue stage
  logic [2:0]          k_r, k_nxt;
  logic                k_last;
  logic                space;
  logic                px_issue;
  logic                wr_en;
  logic                wr_ok;
  logic [7:0]          v;
  logic                v_ok;
  logic [PAL_AW-1:0]   raddr;
  logic [PAL_AW-1:0]   waddr;
  logic [1:0]          op;
  logic [7:0]          mod_val;
  logic [PALETTE_DEPTH-1:0] pal_vld_r;
  logic [PAL_W-1:0]    entry0_r;

  // execute stage
  logic                s2_valid_r;
  logic [1:0]          s2_op_r;
  logic [7:0]          s2_mod_r;
  logic                s2_hit_r;
  logic                s2_first_r;
  logic                s2_row_end_r;
  logic                s2_last_r;
  logic [PAL_W-1:0]    ram_rdata;
  logic [PAL_W-1:0]    pal;
  logic [PAL_W-1:0]    acc_base;
  logic [PAL_W-1:0]    acc_r, acc_nxt;

  // result queue
  out_item_t           o_mem_r [OUT_DEPTH];
  logic [OUT_AW-1:0]   o_wr_r;
  logic [OUT_AW-1:0]   o_rd_r;
  logic [OUT_AW:0]     o_cnt_r;
  logic                o_pop;

  // issue control: one pixel a cycle while the result queue has room
  always_comb begin
    space = ((o_cnt_r + (OUT_AW + 1)'(s2_valid_r)) < (OUT_AW + 1)'(OUT_DEPTH));
    k_last = (({1'b0, k_r} + 4'd1) == q_head.cnt);
    px_issue = q_valid && (q_head.kind == KIND_PIXELS) && (q_head.cnt != '0) && space;
    wr_ok = ({1'b0, q_head.pal_index} < 9'(PALETTE_DEPTH));
    wr_en = q_valid && (q_head.kind == KIND_PAL_WR) && wr_ok;
    q_pop = q_valid && ((q_head.kind == KIND_PAL_WR) || (q_head.cnt == '0) ||
                        (px_issue && k_last));
    k_nxt = k_r;
    if (px_issue) begin
      k_nxt = k_last ? 3'd0 : k_r + 3'd1;
    end
  end

  // pixel decode: operation and modify value per mode
  always_comb begin
    v = q_head.idx[k_r];
    v_ok = ({1'b0, v} < 9'(PALETTE_DEPTH));
    raddr = v[PAL_AW-1:0];
    waddr = q_head.pal_index[PAL_AW-1:0];
    unique case (q_head.mode)
      MODE_HAM6: begin
        op = v[5:4];
        mod_val = {v[3:0], v[3:0]};
      end
      MODE_HAM8: begin
        op = v[7:6];
        mod_val = {v[5:0], v[5:4]};
      end
      default: begin
        op = OP_LOAD;
        mod_val = v;
      end
    endcase
  end

  phpd_ram #(
    .WIDTH (PAL_W),
    .DEPTH (PALETTE_DEPTH),
    .AW    (PAL_AW)
  ) u_pal_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (q_head.pal_color),
    .re    (px_issue),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // issue state, valid bits and entry zero shadow
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      pal_vld_r <= '0;
      entry0_r <= '0;
      s2_valid_r <= 1'b0;
    end else begin
      k_r <= k_nxt;
      s2_valid_r <= px_issue;
      if (wr_en) begin
        pal_vld_r[waddr] <= 1'b1;
        if (q_head.pal_index == '0) begin
          entry0_r <= q_head.pal_color;
        end
      end
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (px_issue) begin
      s2_op_r <= op;
      s2_mod_r <= mod_val;
      s2_hit_r <= v_ok && pal_vld_r[raddr];
      s2_first_r <= q_head.row_start && (k_r == '0);
      s2_row_end_r <= q_head.row_end && k_last;
      s2_last_r <= k_last;
    end
  end

  // accumulator update
  always_comb begin
    pal = s2_hit_r ? ram_rdata : '0;
    acc_base = s2_first_r ? entry0_r : acc_r;
    acc_nxt = acc_r;
    if (s2_valid_r) begin
      unique case (s2_op_r)
        OP_BLUE:  acc_nxt = {acc_base[23:8], s2_mod_r};
        OP_RED:   acc_nxt = {s2_mod_r, acc_base[15:0]};
        OP_GREEN: acc_nxt = {acc_base[23:16], s2_mod_r, acc_base[7:0]};
        default:  acc_nxt = pal;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // result queue
  assign empty = (o_cnt_r == '0);
  assign o_pop = pop && !empty;
  assign out_item = o_mem_r[o_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_wr_r <= '0;
      o_rd_r <= '0;
      o_cnt_r <= '0;
    end else begin
      if (s2_valid_r) begin
        o_wr_r <= o_wr_r + 1'b1;
      end
      if (o_pop) begin
        o_rd_r <= o_rd_r + 1'b1;
      end
      o_cnt_r <= o_cnt_r + (OUT_AW + 1)'(s2_valid_r) - (OUT_AW + 1)'(o_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r) begin
      o_mem_r[o_wr_r] <= '{pixel_rgb: acc_nxt, row_end: s2_row_end_r, last: s2_last_r};
    end
  end

  // result queue never overflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_valid_r && o_cnt_r == (OUT_AW + 1)'(OUT_DEPTH)))
    else $error("result queue overflow");
  // row end falls on the last pixel of its item
  a_row_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_row_end_r) |-> s2_last_r)
    else $error("row end without last");
  // pixel counter stays within the item's visible count
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    px_issue |-> ({1'b0, k_r} < q_head.cnt))
    else $error("pixel counter past visible count");

endmodule
`default_nettype wire

FILE: hdl/planar_ham_pixel_decoder.sv
// top level: configuration registers and the front and back parts
//
// channel  | ports                         | handshake
// ---------+-------------------------------+-------------------------------------
// input    | push, full, in_item           | item taken when push && !full
// result   | empty, pop, out_item          | item taken when pop && !empty
// config   | psel, penable, pwrite, paddr, | write at access phase, pready tied 1
//          | pwdata, prdata, pready        |
//
// a pixel group issues one visible pixel per cycle while the result queue has room;
// the single palette ram read port sets this rate
// a result is registered in the execute stage and then written to the result queue
// reset is synchronous; palette valid bits clear at once
// full and empty stall each side on its own through two small queues
`default_nettype none
module planar_ham_pixel_decoder (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire phpd_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output phpd_pkg::out_item_t      out_item,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import phpd_pkg::*;

  logic [15:0] width_r;
  logic [3:0]  planes_r;
  logic        ham_r;
  logic        cfg_wr;
  cfg_t        cfg;
  logic        q_valid;
  q_entry_t    q_head;
  logic        q_pop;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
      planes_r <= PLANES_RESET;
      ham_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:  width_r <= pwdata[15:0];
        REG_PLANES: planes_r <= pwdata[3:0];
        REG_HAM:    ham_r <= pwdata[0];
        default:    ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {16'd0, width_r};
      REG_PLANES: prdata = {28'd0, planes_r};
      REG_HAM:    prdata = {31'd0, ham_r};
      default:    prdata = '0;
    endcase
  end

  assign cfg = '{image_width: width_r, plane_count: planes_r, ham_enable: ham_r};

  phpd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  phpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
`default_nettype wire
